@@ hdl/msr_pkg.sv @@
// ----------------------------------------------------------------------------
// msr_pkg
// shared types and constants of the multi-channel servo slew ramp
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int CHANNELS_DEF = 6;

    localparam int PULSE_W  = 13;
    localparam int PERIOD_W = 15;
    localparam int COUNT_W  = 16;
    localparam int CHAN_W   = 3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // configuration register indexes
    localparam logic CFG_MIN_PULSE = 1'b0;
    localparam logic CFG_MAX_PULSE = 1'b1;

    // input kinds
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = PULSE_W'(180);
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = PULSE_W'(900);
    localparam logic [PULSE_W-1:0] PULSE_RST     = PULSE_W'((180 + 900) / 2);
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

    // controller to datapath commands
    typedef struct packed {
        logic load;       // latch the incoming request
        logic tick_step;  // update one channel for a tick and present it
        logic set_step;   // apply the latched set request if it can be taken and present it
        logic last;       // final result of this request
    } msr_cmd_t;

endpackage

@@ hdl/msr_ctrl.sv @@
// ----------------------------------------------------------------------------
// msr_ctrl
// sequencer: takes a request, then walks the channels or applies one set
// ----------------------------------------------------------------------------
module msr_ctrl #(
    parameter int CHANNELS = msr_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    output logic             s_tready,
    input  logic             out_free,
    output msr_pkg::msr_cmd_t cmd,
    output logic [IDX_W-1:0] idx
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_SET  = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    state_next = (s_tuser == msr_pkg::ACT_SET) ? ST_SET : ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    cmd.tick_step = 1'b1;
                    cmd.last      = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_SET:
            begin
                if (out_free)
                begin
                    cmd.set_step = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idx = idx_reg;

endmodule

@@ hdl/msr_datapath.sv @@
// ----------------------------------------------------------------------------
// msr_datapath
// per-channel ramp state, limit registers, update logic and output register
// ----------------------------------------------------------------------------
module msr_datapath #(
    parameter int CHANNELS = msr_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [msr_pkg::PULSE_W-1:0]         cfg_data,
    input  logic [msr_pkg::CHAN_W-1:0]          in_channel,
    input  logic [msr_pkg::PULSE_W-1:0]         in_target,
    input  logic [msr_pkg::PERIOD_W-1:0]        in_period,
    input  msr_pkg::msr_cmd_t                   cmd,
    input  logic [IDX_W-1:0]                    idx,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [msr_pkg::CHAN_W-1:0]          o_channel,
    output logic [msr_pkg::PULSE_W-1:0]         o_pulse,
    output logic                                o_moving,
    output logic                                o_accepted,
    output logic                                o_last
);

    localparam int PW = msr_pkg::PULSE_W;
    localparam int QW = msr_pkg::PERIOD_W;
    localparam int CW = msr_pkg::COUNT_W;

    logic [PW-1:0] min_reg, max_reg;
    logic [msr_pkg::CHAN_W-1:0] ch_reg;
    logic [PW-1:0] tgt_reg;
    logic [QW-1:0] per_reg;

    logic [PW-1:0] cur_reg  [CHANNELS];
    logic [PW-1:0] goal_reg [CHANNELS];
    logic [CW-1:0] cnt_reg  [CHANNELS];
    logic [QW-1:0] pst_reg  [CHANNELS];
    logic [CHANNELS-1:0] run_reg;
    logic [CHANNELS-1:0] down_reg;

    logic                       out_valid_reg;
    logic [msr_pkg::CHAN_W-1:0] o_channel_reg;
    logic [PW-1:0]              o_pulse_reg;
    logic                       o_moving_reg, o_accepted_reg, o_last_reg;

    // channel addressed by the set request
    logic [15:0]      set_wide;
    logic [IDX_W-1:0] set_idx;
    logic             set_valid;
    logic [15:0]      tick_wide;

    // tick update of the visited channel
    logic [PW-1:0] t_cur, t_cur_next;
    logic [CW-1:0] t_cnt, t_cnt_inc, t_cnt_next;
    logic [QW-1:0] t_per;
    logic          t_run, t_run_next;

    // set request
    logic [PW-1:0] s_lo, s_goal;
    logic          s_run, s_take;

    assign set_wide  = 16'(ch_reg);
    assign set_idx   = set_wide[IDX_W-1:0];
    assign set_valid = ({2'b00, ch_reg} < 5'(CHANNELS));
    assign tick_wide = 16'(idx);

    always_comb
    begin
        t_cur      = cur_reg[idx];
        t_cnt      = cnt_reg[idx];
        t_run      = run_reg[idx];
        t_per      = (pst_reg[idx] == '0) ? QW'(1) : pst_reg[idx];
        t_cnt_inc  = (t_cnt == msr_pkg::COUNT_MAX) ? t_cnt : t_cnt + 1'b1;
        t_cur_next = t_cur;
        t_cnt_next = t_cnt;
        t_run_next = t_run;
        if (t_run)
        begin
            if (t_cur == goal_reg[idx])
            begin
                t_run_next = 1'b0;
            end
            else if (t_cnt_inc >= CW'(t_per))
            begin
                t_cnt_next = '0;
                t_cur_next = down_reg[idx] ? t_cur - 1'b1 : t_cur + 1'b1;
            end
            else
            begin
                t_cnt_next = t_cnt_inc;
            end
        end
    end

    always_comb
    begin
        s_lo   = (tgt_reg <= min_reg) ? min_reg : tgt_reg;
        s_goal = (s_lo >= max_reg) ? max_reg : s_lo;
        s_run  = run_reg[set_idx];
        s_take = set_valid && !s_run;
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= msr_pkg::MIN_PULSE_RST;
            max_reg <= msr_pkg::MAX_PULSE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == msr_pkg::CFG_MIN_PULSE)
            begin
                min_reg <= cfg_data;
            end
            else
            begin
                max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg  <= in_channel;
            tgt_reg <= in_target;
            per_reg <= in_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                cur_reg[c]  <= msr_pkg::PULSE_RST;
                goal_reg[c] <= msr_pkg::PULSE_RST;
                cnt_reg[c]  <= '0;
                pst_reg[c]  <= msr_pkg::PERIOD_RST;
            end
            run_reg  <= '0;
            down_reg <= '0;
        end
        else if (cmd.tick_step)
        begin
            cur_reg[idx] <= t_cur_next;
            cnt_reg[idx] <= t_cnt_next;
            run_reg[idx] <= t_run_next;
        end
        else if (cmd.set_step && s_take)
        begin
            // count is left alone on purpose
            goal_reg[set_idx] <= s_goal;
            pst_reg[set_idx]  <= per_reg;
            down_reg[set_idx] <= (cur_reg[set_idx] >= s_goal);
            run_reg[set_idx]  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.tick_step || cmd.set_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_step)
        begin
            o_channel_reg  <= tick_wide[msr_pkg::CHAN_W-1:0];
            o_pulse_reg    <= t_cur_next;
            o_moving_reg   <= t_run_next;
            o_accepted_reg <= 1'b0;
            o_last_reg     <= cmd.last;
        end
        else if (cmd.set_step)
        begin
            o_channel_reg  <= ch_reg;
            o_pulse_reg    <= set_valid ? cur_reg[set_idx] : '0;
            o_moving_reg   <= set_valid;
            o_accepted_reg <= s_take;
            o_last_reg     <= cmd.last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign o_channel  = o_channel_reg;
    assign o_pulse    = o_pulse_reg;
    assign o_moving   = o_moving_reg;
    assign o_accepted = o_accepted_reg;
    assign o_last     = o_last_reg;

endmodule

@@ hdl/multi_servo_slew_ramp_core.sv @@
// ----------------------------------------------------------------------------
// multi_servo_slew_ramp_core
// slew-rate limited pulse-width ramps for a bank of servo channels
// ----------------------------------------------------------------------------
// input stream: s_tuser selects a tick (0) or a set-target request (1);
// s_tdata carries channel, target and step period
// a tick returns one result per channel in channel order, the final one with
// m_tlast set; a set request returns a single result with m_tlast set
// a request is taken only while the sequencer is idle; after that a tick
// steps through the channels one at a time and a set is applied once;
// each step waits for the output register to be free
// the request is latched first; each result is then registered at the output
// results sit in an output register; while the receiver stalls, the
// sequencer holds its steps and no channel state changes until the result is taken
// min_pulse and max_pulse are written over cfg_we / cfg_index / cfg_data
// and affect only later set requests
// reset returns every channel to a stopped state at the mid pulse width and
// restores the default limits; no clearing pass is needed
// ----------------------------------------------------------------------------
module multi_servo_slew_ramp_core #(
    parameter int CHANNELS = msr_pkg::CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [msr_pkg::PULSE_W-1:0]       cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] channel, [15:3] target, [30:16] step_period, [31] zero
    input  logic [msr_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] action
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] out_channel, [15:3] pulse_width, [16] moving, [17] accepted, [23:18] zero
    output logic [msr_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    msr_pkg::msr_cmd_t          cmd;
    logic [IDX_W-1:0]           idx;
    logic                       out_free;
    logic [msr_pkg::CHAN_W-1:0] o_channel;
    logic [msr_pkg::PULSE_W-1:0] o_pulse;
    logic                       o_moving, o_accepted;

    msr_ctrl #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .out_free (out_free),
        .cmd      (cmd),
        .idx      (idx)
    );

    msr_datapath #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_channel (s_tdata[2:0]),
        .in_target  (s_tdata[15:3]),
        .in_period  (s_tdata[30:16]),
        .cmd        (cmd),
        .idx        (idx),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .o_channel  (o_channel),
        .o_pulse    (o_pulse),
        .o_moving   (o_moving),
        .o_accepted (o_accepted),
        .o_last     (m_tlast)
    );

    assign m_tdata = {6'b000000, o_accepted, o_moving, o_pulse, o_channel};

`ifndef SYNTH
    // a taken set leaves the channel running and ends the request
    a_accept_moving_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> m_tdata[16] && m_tlast)
        else $error("accepted set without moving or last");

    // no new request while one is in progress
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a stalled result is never overwritten
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed during stall");
`endif

endmodule
